// File: hw/rtl/ordered_list_append_search_delete_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list block
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_APPEND_SEARCH_DELETE_TOP_DEFINES_SVH
`define ORDERED_LIST_APPEND_SEARCH_DELETE_TOP_DEFINES_SVH

// same-cycle implication
`define OLASD_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define OLASD_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/olasd_pkg.sv
// ----------------------------------------------------------------------------
// olasd_pkg
// Types and constants shared by the ordered list cells and top level.
// ----------------------------------------------------------------------------
package olasd_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int MODE_W       = 2;
  localparam int COUNT_OUT_W  = 5;

  // operation codes carried by an item
  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_DELETE = 2'd2
  } mode_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic tok;   // scan front is at this link
    logic hit;   // a match was seen in an earlier cell
  } link_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic [VALUE_W-1:0] key;
    logic               commit_shift;  // close the gap left by a delete
  } bcast_t;

endpackage

// File: hw/rtl/ordered_list_append_search_delete_top.sv
// ----------------------------------------------------------------------------
// ordered_list_append_search_delete_top
// Bounded ordered list of signed values with append, search and delete.
// ----------------------------------------------------------------------------
// Usage:
//   An item (mode, value) is taken at a rising edge with start high and
//   busy low. Each item yields one result (found, full_reject, entry_count)
//   shown for exactly one cycle with done high; the receiver cannot stall.
// Throughput:
//   Append and the unused mode finish at once: done comes in the cycle after
//   the accept, busy stays low, so one such item per cycle.
//   Search and delete send a token down the row of CAPACITY cells, one cell
//   per cycle; busy stays high while the token travels, and done follows in
//   the cycle busy drops. The next item is taken at the end of that cycle,
//   so a new item is not taken before the last one is through. The length
//   of the cell chain sets how long busy stays high.
//   A delete closes the gap at the end of the scan: every cell at or after
//   the first match loads its right neighbor.
// Reset:
//   rst clears the entry count (list empty) and the sequencer; slot
//   contents are left as they are and are never read until written.
// ----------------------------------------------------------------------------
`include "ordered_list_append_search_delete_top_defines.svh"

module ordered_list_append_search_delete_top
  import olasd_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [MODE_W-1:0]         mode,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      done,
  output logic                      found,
  output logic                      full_reject,
  output logic [COUNT_OUT_W-1:0]    entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [VALUE_W-1:0] key, key_next;
  logic               op_del, op_del_next;
  logic               seed, seed_next;
  logic               done_next, found_next, full_next;
  logic               accept;
  logic               is_full;
  logic               do_append;
  logic               scan_op;
  bcast_t             bc;

  link_t              links [CAPACITY+1];
  logic [VALUE_W-1:0] cell_data [CAPACITY];

  assign accept  = start && !busy;
  assign is_full = (count == CNT_W'(CAPACITY));
  assign busy    = (state != ST_IDLE);
  assign scan_op = (mode == MODE_SEARCH) || (mode == MODE_DELETE);
  assign links[0] = '{tok: seed, hit: 1'b0};

  // sequencer: decode, scan wait, commit
  always_comb begin
    state_next   = state;
    count_next   = count;
    key_next     = key;
    op_del_next  = op_del;
    seed_next    = 1'b0;
    done_next    = 1'b0;
    found_next   = 1'b0;
    full_next    = 1'b0;
    do_append    = 1'b0;
    bc.key          = key;
    bc.commit_shift = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_t'(mode))
            MODE_APPEND: begin
              done_next = 1'b1;
              if (is_full) begin
                full_next = 1'b1;
              end else begin
                do_append  = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            MODE_SEARCH, MODE_DELETE: begin
              key_next    = value;
              op_del_next = (mode_t'(mode) == MODE_DELETE);
              seed_next   = 1'b1;
              state_next  = ST_SCAN;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (links[CAPACITY].tok) begin
          done_next  = 1'b1;
          found_next = links[CAPACITY].hit;
          state_next = ST_IDLE;
          if (op_del && links[CAPACITY].hit) begin
            bc.commit_shift = 1'b1;
            count_next      = count - CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      seed  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      seed  <= seed_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key         <= key_next;
    op_del      <= op_del_next;
    found       <= found_next;
    full_reject <= full_next;
    entry_count <= COUNT_OUT_W'(count_next);
  end

  // row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_W-1:0] nbr;
    if (g < CAPACITY - 1) begin : g_mid
      assign nbr = cell_data[g+1];
    end else begin : g_last
      assign nbr = cell_data[g];
    end
    olasd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid    (count > CNT_W'(g)),
      .wr_en    (do_append && (count == CNT_W'(g))),
      .wr_data  (value),
      .nbr_data (nbr),
      .bc       (bc),
      .link_in  (links[g]),
      .link_out (links[g+1]),
      .data     (cell_data[g])
    );
  end

  // checks
  `OLASD_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "count above capacity")
  `OLASD_ASSERT_NXT(a_scan_busy, accept && scan_op, busy, "scan not started")
  `OLASD_ASSERT_IMP(a_flags_excl, done, !(found && full_reject), "found and full_reject both set")
  `OLASD_ASSERT_NXT(a_count_step, !busy && !accept, count == $past(count), "count moved while idle")

endmodule

// File: hw/rtl/olasd_cell.sv
// ----------------------------------------------------------------------------
// olasd_cell
// One list slot: holds a value, compares it with the key as the scan
// token passes, and pulls its right neighbor's value on a delete.
// ----------------------------------------------------------------------------
module olasd_cell
  import olasd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  input  logic               wr_en,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic [VALUE_W-1:0] nbr_data,
  input  bcast_t             bc,
  input  link_t              link_in,
  output link_t              link_out,
  output logic [VALUE_W-1:0] data
);

  logic match;
  logic shift;

  assign match = valid && (data == bc.key);

  // stored value: append write or shift toward the head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      data <= wr_data;
    end else if (bc.commit_shift && shift) begin
      data <= nbr_data;
    end
  end

  // token pass; remember whether this slot sits at or after the first match
  // hit runs beside the token and needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.tok <= 1'b0;
      shift        <= 1'b0;
    end else begin
      link_out.tok <= link_in.tok;
      if (link_in.tok) begin
        shift <= link_in.hit | match;
      end
    end
    link_out.hit <= link_in.hit | match;
  end

endmodule
